// File: design/bqn_pkg.sv
package bqn_pkg;

  // Default widths of the filter core
  localparam int DEF_SAMPLE_WIDTH   = 16;
  localparam int DEF_COEF_FRAC_BITS = 20;

  // Coefficients are signed Q3.F, the gain is unsigned Q3.F
  localparam int COEF_INT_BITS = 4;
  localparam int GAIN_INT_BITS = 3;

  // Register index width on the config port
  localparam int CFG_IDX_W = 3;

  // Number of products in the direct-form-1 sum
  localparam int MAC_TERMS = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_COEF_B0  = 3'd1,
    REG_COEF_B1  = 3'd2,
    REG_COEF_B2  = 3'd3,
    REG_COEF_A1  = 3'd4,
    REG_COEF_A2  = 3'd5,
    REG_INV_GAIN = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_SCALE,
    S_ROUND
  } state_t;

  typedef enum logic [2:0] {
    TERM_B0,
    TERM_B1,
    TERM_B2,
    TERM_A1,
    TERM_A2
  } mac_term_t;

endpackage

// File: design/biquad_notch_filter_core.sv
// Direct-form-1 biquad (notch) filter, one signed sample in, one signed
// sample out. Each transfer on the input channel yields exactly one transfer
// on the output channel. All arithmetic goes through a single signed
// multiplier under a small sequencer: the multiply-accumulate state builds
// the full-precision sum x0*b0 + x1*b1 + x2*b2 - y1*a1 - y2*a2, then the sum
// is cut into SAMPLE_WIDTH-bit chunks and multiplied by inv_gain one chunk a
// cycle (three chunks at the default widths), then the round state rounds
// half up, shifts right by 2*COEF_FRAC_BITS and saturates. With enable low
// the sample skips the multiply and scale states and goes straight to the
// round state. in_ready is high only while the sequencer is idle; a finished
// result sits in the output register, so the next sample can be taken while
// the previous result still waits for out_ready. Coefficient registers are
// to be written through cfg_we/cfg_index/cfg_data only while the block is
// idle; the user is bound to this and the block leaves it unchecked. Writes
// to an unknown index are dropped. Reset clears the sample histories and
// loads unity gain (b0 = inv_gain = 1.0, others 0) with the filter bypassed.
module biquad_notch_filter_core #(
  parameter int SAMPLE_WIDTH   = bqn_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = bqn_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // config write port
  input  logic                                      cfg_we,
  input  logic [bqn_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [COEF_FRAC_BITS+bqn_pkg::COEF_INT_BITS-1:0] cfg_data,
  // sample input
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]            sample_in,
  // filtered output
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]            sample_out,
  output logic                                      saturated
);

  import bqn_pkg::*;

  // Widths
  localparam int SW  = SAMPLE_WIDTH;
  localparam int FB  = COEF_FRAC_BITS;
  localparam int CW  = FB + COEF_INT_BITS;       // coefficient width
  localparam int GW  = FB + GAIN_INT_BITS;       // gain width
  localparam int MW  = SW + CW + 2;              // multiplier product
  localparam int AW  = SW + CW + 3;              // five-term sum
  localparam int NCH = (AW + SW - 1) / SW;       // sum chunks for scaling
  localparam int EW  = NCH * SW;                 // sum extended to chunks
  localparam int PW  = EW + CW + 2;              // scaled product, one spare bit
  localparam int CH_W = $clog2(NCH);
  localparam int SH  = 2 * FB;                   // final right shift

  localparam logic [PW-1:0]        RND_HALF = PW'(1) << (SH - 1);
  localparam logic [CH_W-1:0]      CH_TOP   = CH_W'(NCH - 1);
  localparam logic signed [SW-1:0] S_MAX    = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN    = {1'b1, {(SW-1){1'b0}}};

  // Configuration registers
  logic                 enable;
  logic signed [CW-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [GW-1:0]        inv_gain;

  // Filter state
  logic signed [SW-1:0] x0, in_prev1, in_prev2, out_prev1, out_prev2;

  // Sequencer
  state_t          state, state_next;
  mac_term_t       step;
  logic [CH_W-1:0] chunk_idx;

  // Datapath
  logic signed [AW-1:0] acc;
  logic signed [PW-1:0] pacc;
  logic signed [SW:0]   mul_a;
  logic signed [CW:0]   mul_b;
  logic signed [MW-1:0] mul_p;
  logic signed [AW-1:0] term;
  logic signed [PW-1:0] term_ext;
  logic [EW-1:0]        acc_ext;
  logic [SW-1:0]        chunk [NCH];
  logic [PW-1:0]        rnd;
  logic                 hi_ones, hi_zeros;
  logic signed [SW-1:0] y_val;
  logic                 y_sat;
  logic                 out_free;
  logic                 in_xfer;

  // ---------------------------------------------------------------------
  // Config writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= 1'b0;
      coef_b0  <= CW'(1) << FB;
      coef_b1  <= '0;
      coef_b2  <= '0;
      coef_a1  <= '0;
      coef_a2  <= '0;
      inv_gain <= GW'(1) << FB;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE:   enable   <= cfg_data[0];
        REG_COEF_B0:  coef_b0  <= cfg_data;
        REG_COEF_B1:  coef_b1  <= cfg_data;
        REG_COEF_B2:  coef_b2  <= cfg_data;
        REG_COEF_A1:  coef_a1  <= cfg_data;
        REG_COEF_A2:  coef_a2  <= cfg_data;
        REG_INV_GAIN: inv_gain <= cfg_data[GW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  assign out_free = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = enable ? S_MAC : S_ROUND;
      end
      S_MAC: begin
        if (step == TERM_A2) state_next = S_SCALE;
      end
      S_SCALE: begin
        if (chunk_idx == '0) state_next = S_ROUND;
      end
      S_ROUND: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer outputs: handshake and multiplier operand select
  // ---------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      chunk[i] = acc_ext[i*SW +: SW];
    end
  end

  // acc is signed, so the cast sign-extends
  assign acc_ext = EW'(acc);

  always_comb begin
    in_ready = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_MAC: begin
        case (step)
          TERM_B0: begin mul_a = {x0[SW-1], x0};               mul_b = {coef_b0[CW-1], coef_b0}; end
          TERM_B1: begin mul_a = {in_prev1[SW-1], in_prev1};   mul_b = {coef_b1[CW-1], coef_b1}; end
          TERM_B2: begin mul_a = {in_prev2[SW-1], in_prev2};   mul_b = {coef_b2[CW-1], coef_b2}; end
          TERM_A1: begin mul_a = {out_prev1[SW-1], out_prev1}; mul_b = {coef_a1[CW-1], coef_a1}; end
          TERM_A2: begin mul_a = {out_prev2[SW-1], out_prev2}; mul_b = {coef_a2[CW-1], coef_a2}; end
          default: ;
        endcase
      end
      S_SCALE: begin
        // top chunk carries the sign, lower chunks are unsigned digits
        if (chunk_idx == CH_TOP) begin
          mul_a = {chunk[chunk_idx][SW-1], chunk[chunk_idx]};
        end else begin
          mul_a = {1'b0, chunk[chunk_idx]};
        end
        mul_b = {2'b00, inv_gain};
      end
      default: ;
    endcase
  end

  // The one shared multiplier
  assign mul_p = mul_a * mul_b;

  assign term     = {{(AW-MW){mul_p[MW-1]}}, mul_p};
  assign term_ext = {{(PW-MW){mul_p[MW-1]}}, mul_p};

  // ---------------------------------------------------------------------
  // Round half up, shift, saturate
  // ---------------------------------------------------------------------
  assign rnd      = pacc + RND_HALF;
  assign hi_ones  = &rnd[PW-1:SH+SW-1];
  assign hi_zeros = ~|rnd[PW-1:SH+SW-1];

  always_comb begin
    y_val = x0;
    y_sat = 1'b0;
    if (enable) begin
      if (hi_ones || hi_zeros) begin
        y_val = rnd[SH+SW-1:SH];
      end else begin
        y_val = rnd[PW-1] ? S_MIN : S_MAX;
        y_sat = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= TERM_B0;
      chunk_idx <= CH_TOP;
      out_valid <= 1'b0;
      in_prev1  <= '0;
      in_prev2  <= '0;
      out_prev1 <= '0;
      out_prev2 <= '0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        step <= TERM_B0;
      end else if (state == S_MAC) begin
        step <= mac_term_t'(step + 3'd1);
      end
      if (state == S_MAC) begin
        chunk_idx <= CH_TOP;
      end else if (state == S_SCALE) begin
        chunk_idx <= chunk_idx - CH_W'(1);
      end
      if (state == S_ROUND && out_free) begin
        out_valid <= 1'b1;
        in_prev2  <= in_prev1;
        in_prev1  <= x0;
        out_prev2 <= out_prev1;
        out_prev1 <= y_val;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer) x0 <= sample_in;
    if (state == S_MAC) begin
      case (step)
        TERM_B0:          acc <= term;
        TERM_A1, TERM_A2: acc <= acc - term;
        default:          acc <= acc + term;
      endcase
    end
    if (state == S_SCALE) begin
      // chunks go top down: pacc = pacc * 2^SW + chunk * gain
      if (chunk_idx == CH_TOP) pacc <= term_ext;
      else                     pacc <= (pacc <<< SW) + term_ext;
    end
    if (state == S_ROUND && out_free) begin
      sample_out <= y_val;
      saturated  <= y_sat;
    end
  end

`ifndef SYNTHESIS
  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && out_valid && !out_ready) |=> (state == S_ROUND))
    else $error("result overwritten while output pending");

  // the stored feedback sample matches what was delivered
  a_feedback: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && out_free) |=> (out_valid && out_prev1 == sample_out))
    else $error("y1 history differs from result");

  // clipping flag only with a rail value
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (sample_out == S_MAX || sample_out == S_MIN))
    else $error("saturated flag without rail value");

  // bypass never reports clipping
  a_bypass_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !enable) |-> !saturated)
    else $error("saturated flag in bypass");

  // an accepted sample goes to the MAC phase or straight to output
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_MAC || state == S_ROUND))
    else $error("sequencer did not start");
`endif

endmodule

// File: bench/testbench.sv
// Checks the direct-form-1 biquad core against a bit-exact predictor that
// runs alongside it. A short directed table opens the run: bypass mode,
// unity gain, clipping at both rails, the unused register index, upper
// bits of the enable and gain registers, and zero gain. Four idling phases
// follow. Each phase walks every coefficient setting type with random
// samples.
module testbench;
  import bqn_pkg::*;

  localparam int SW = DEF_SAMPLE_WIDTH;
  localparam int FB = DEF_COEF_FRAC_BITS;
  localparam int CW = FB + COEF_INT_BITS;   // signed coefficient width
  localparam int GW = FB + GAIN_INT_BITS;   // unsigned gain width

  // No register sits at this index, so a write to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Rounding and clipping constants for the predictor, at 96 bits.
  localparam logic signed [95:0] ROUND_HALF = 96'sd1 <<< (2*FB - 1);
  localparam logic signed [95:0] SAT_MAX    = (96'sd1 <<< (SW - 1)) - 1;
  localparam logic signed [95:0] SAT_MIN    = -(96'sd1 <<< (SW - 1));

  localparam int SAMPLES_PER_SETTING = 100;

  typedef struct packed {
    logic signed [SW-1:0] value;
    logic                 clip;
  } filt_result_t;

  typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CW-1:0]        data;      // register data, or the sample in the low bits
    bit                   pinned;    // expected output typed in below
    logic [SW-1:0]        exp_value;
    logic                 exp_clip;
  } dir_row_t;

  typedef enum {SET_NOTCH, SET_RANDOM, SET_EXTREME, SET_SMALL, SET_BYPASS} setting_t;

  // ---------------------------------------------------------------------
  // Clock, reset and DUT pins; every input is known from time zero
  // ---------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0]        cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic signed [SW-1:0] sample_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [SW-1:0] sample_out;
  logic                 saturated;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  biquad_notch_filter_core DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .saturated  (saturated)
  );

  // ---------------------------------------------------------------------
  // Predictor state: register copy and sample histories, at reset values
  // ---------------------------------------------------------------------
  logic                 flt_enable = 1'b0;
  logic signed [CW-1:0] flt_b0     = CW'(1 << FB);
  logic signed [CW-1:0] flt_b1     = '0;
  logic signed [CW-1:0] flt_b2     = '0;
  logic signed [CW-1:0] flt_a1     = '0;
  logic signed [CW-1:0] flt_a2     = '0;
  logic [GW-1:0]        flt_gain   = GW'(1 << FB);
  logic signed [SW-1:0] hist_x1 = '0, hist_x2 = '0;
  logic signed [SW-1:0] hist_y1 = '0, hist_y2 = '0;

  filt_result_t expected_samples[$];
  int           mismatches = 0;

  // Idle rates in percent, changed per phase
  int gap_pct   = 0;
  int stall_pct = 0;

  // A directed row with a typed expectation overrides the predictor output
  bit           pin_active = 1'b0;
  filt_result_t pin_value  = '0;

  // One sample through the filter. Histories shift in both modes; y1 takes
  // the clipped value, or the raw input when bypassed.
  function automatic filt_result_t filter_step(input logic signed [SW-1:0] x);
    logic signed [95:0] acc, prod, q;
    filt_result_t       r;
    if (flt_enable) begin
      acc  = x * flt_b0 + hist_x1 * flt_b1 + hist_x2 * flt_b2
           - hist_y1 * flt_a1 - hist_y2 * flt_a2;
      prod = acc * $signed({1'b0, flt_gain});
      q    = (prod + ROUND_HALF) >>> (2*FB);   // floor shift after +half
      r.clip = 1'b1;
      if (q > SAT_MAX) begin
        r.value = {1'b0, {(SW-1){1'b1}}};
      end else if (q < SAT_MIN) begin
        r.value = {1'b1, {(SW-1){1'b0}}};
      end else begin
        r.value = q[SW-1:0];
        r.clip  = 1'b0;
      end
    end else begin
      r.value = x;
      r.clip  = 1'b0;
    end
    hist_x2 = hist_x1;
    hist_x1 = x;
    hist_y2 = hist_y1;
    hist_y1 = r.value;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input filt_result_t want,
                               input filt_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected sample %0d sat %0b, got sample %0d sat %0b",
               $time, what, $signed(want.value), want.clip,
               $signed(got.value), got.clip);
  endtask

  // ---------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge. Output side first
  // so that an output transfer with an empty queue is never masked.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    filt_result_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{value: sample_out, clip: saturated};
        if (expected_samples.size() == 0) begin
          note_mismatch("output transfer with nothing expected", '0, got);
        end else begin
          want = expected_samples.pop_front();
          if (got.value !== want.value || got.clip !== want.clip)
            note_mismatch("output mismatch", want, got);
        end
      end
      if (in_valid && in_ready) begin
        want = filter_step(sample_in);
        if (pin_active)
          want = pin_value;
        expected_samples.push_back(want);
      end
    end
  end

  // Receiver: stalls at random at the phase's rate
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------
  // Driver tasks; everything changes at the falling edge
  // ---------------------------------------------------------------------

  // Offer one sample, with random idle cycles first, and hold it until the
  // transfer happens.
  task automatic send_sample(input logic signed [SW-1:0] x, input bit pin,
                             input filt_result_t pinned_r);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pin_active = pin;
    pin_value  = pinned_r;
    sample_in <= x;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every expected output has arrived.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One register write; only called while the core is idle, so the
  // predictor copy can be updated right away.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
    case (idx)
      REG_ENABLE:   flt_enable = data[0];
      REG_COEF_B0:  flt_b0     = data;
      REG_COEF_B1:  flt_b1     = data;
      REG_COEF_B2:  flt_b2     = data;
      REG_COEF_A1:  flt_a1     = data;
      REG_COEF_A2:  flt_a2     = data;
      REG_INV_GAIN: flt_gain   = data[GW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Load a full register set of the given kind. Upper bits of the enable
  // and gain writes are random, since the core must ignore them.
  task automatic load_setting(input setting_t kind);
    longint        c, r;
    logic [CW-1:0] b0, b1, b2, a1, a2;
    logic [GW-1:0] gain;
    b0   = CW'($urandom);
    b1   = CW'($urandom);
    b2   = CW'($urandom);
    a1   = CW'($urandom);
    a2   = CW'($urandom);
    gain = GW'($urandom);
    case (kind)
      SET_NOTCH: begin
        // zeros on the unit circle at angle w, poles at radius r
        c    = longint'($urandom_range(2097152)) - 1048576;   // cos(w), Q20
        r    = longint'($urandom_range(1038090, 734003));     // 0.70 .. 0.99
        b0   = CW'(1 << FB);
        b2   = CW'(1 << FB);
        b1   = CW'(-2 * c);
        a1   = CW'(-((2 * r * c) >>> FB));
        a2   = CW'((r * r) >>> FB);
        gain = GW'($urandom_range(1 << FB, 1 << (FB - 1)));
      end
      SET_EXTREME: begin
        b0   = $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
        b1   = $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
        b2   = $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
        a1   = $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
        a2   = $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
        gain = $urandom_range(1) ? '1 : '0;
      end
      SET_SMALL: begin
        b0   = CW'($urandom_range(1 << 19) - (1 << 18));
        b1   = CW'($urandom_range(1 << 19) - (1 << 18));
        b2   = CW'($urandom_range(1 << 19) - (1 << 18));
        a1   = CW'($urandom_range(1 << 19) - (1 << 18));
        a2   = CW'($urandom_range(1 << 19) - (1 << 18));
        gain = GW'($urandom_range(1 << (FB + 1), 1 << (FB - 1)));
      end
      default: ;  // SET_RANDOM and SET_BYPASS keep the raw random values
    endcase
    cfg_write(REG_ENABLE,   {(CW-1)'($urandom), kind != SET_BYPASS});
    cfg_write(REG_COEF_B0,  b0);
    cfg_write(REG_COEF_B1,  b1);
    cfg_write(REG_COEF_B2,  b2);
    cfg_write(REG_COEF_A1,  a1);
    cfg_write(REG_COEF_A2,  a2);
    cfg_write(REG_INV_GAIN, {1'($urandom), gain});
  endtask

  // ---------------------------------------------------------------------
  // Directed table. Typed expectations only where they are plain: bypass,
  // unity gain, clipping at the rails, zero gain.
  // ---------------------------------------------------------------------
  dir_row_t dir_rows [26] = '{
    // bypassed after reset: output equals input
    '{ROW_SAMPLE, '0,           24'h000000, 1'b1, 16'h0000, 1'b0},
    '{ROW_SAMPLE, '0,           24'h007FFF, 1'b1, 16'h7FFF, 1'b0},
    '{ROW_SAMPLE, '0,           24'h008000, 1'b1, 16'h8000, 1'b0},
    '{ROW_SAMPLE, '0,           24'h00A5A5, 1'b1, 16'hA5A5, 1'b0},
    // enable bit 0 clear, upper bits set: still bypassed
    '{ROW_WRITE,  REG_ENABLE,   24'hFFFFFE, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, '0,           24'h001234, 1'b1, 16'h1234, 1'b0},
    // filtering with the reset coefficients is the identity
    '{ROW_WRITE,  REG_ENABLE,   24'h000001, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, '0,           24'h008000, 1'b1, 16'h8000, 1'b0},
    '{ROW_SAMPLE, '0,           24'h007FFF, 1'b1, 16'h7FFF, 1'b0},
    // b0 near +8 drives full-scale inputs into both rails
    '{ROW_WRITE,  REG_COEF_B0,  24'h7FFFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, '0,           24'h007FFF, 1'b1, 16'h7FFF, 1'b1},
    '{ROW_SAMPLE, '0,           24'h008000, 1'b1, 16'h8000, 1'b1},
    // unused index must not touch any register
    '{ROW_WRITE,  REG_UNUSED,   24'h123456, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, '0,           24'h000064, 1'b0, 16'h0000, 1'b0},
    // every coefficient at a rail, gain with its ignored top bit set
    '{ROW_WRITE,  REG_COEF_B1,  24'h800000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WRITE,  REG_COEF_B2,  24'h7FFFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_WRITE,  REG_COEF_A1,  24'h800000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WRITE,  REG_COEF_A2,  24'h7FFFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_WRITE,  REG_INV_GAIN, 24'hFFFFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, '0,           24'h000001, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, '0,           24'h00FFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, '0,           24'h004000, 1'b0, 16'h0000, 1'b0},
    // zero gain: rounding leaves exactly zero
    '{ROW_WRITE,  REG_INV_GAIN, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, '0,           24'h003039, 1'b1, 16'h0000, 1'b0},
    // back to bypass with odd coefficients still loaded
    '{ROW_WRITE,  REG_ENABLE,   24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, '0,           24'h008001, 1'b1, 16'h8001, 1'b0}
  };

  // Idle phases: {sender gap %, receiver stall %}
  int phase_gap   [4] = '{0, 64,  0, 26};
  int phase_stall [4] = '{0,  0, 64, 26};

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic signed [SW-1:0] s;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        cfg_write(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_sample(dir_rows[i].data[SW-1:0], dir_rows[i].pinned,
                    '{value: dir_rows[i].exp_value, clip: dir_rows[i].exp_clip});
      end
    end
    wait_drained();

    // Random part: every setting type under every idle pattern
    for (int p = 0; p < 4; p++) begin
      gap_pct   = phase_gap[p];
      stall_pct = phase_stall[p];
      for (int k = SET_NOTCH; k <= SET_BYPASS; k++) begin
        wait_drained();
        load_setting(setting_t'(k));
        for (int i = 0; i < SAMPLES_PER_SETTING; i++) begin
          // mid-setting pause until the core has emptied
          if (i == SAMPLES_PER_SETTING / 2)
            wait_drained();
          case ($urandom_range(9))
            0:       s = $urandom_range(1) ? {1'b0, {(SW-1){1'b1}}}
                                           : {1'b1, {(SW-1){1'b0}}};
            1:       s = SW'($urandom_range(255) - 128);
            default: s = SW'($urandom);
          endcase
          send_sample(s, 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
